[rtl/rotary_encoder_button_decoder_unit_defines.svh]
// Assertion macros for the rotary encoder and button decoder.
// Included by the top level only; needs no package.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_UNIT_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_UNIT_DEFINES_SVH

// Property checked on every clock edge, quiet while reset is high.
`define REBD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define REBD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/rebd_pkg.sv]
// Shared types and constants for the rotary encoder and button decoder.
// No dependencies; imported by rotary_encoder_button_decoder_unit.
`default_nettype none

package rebd_pkg;

   // Input word: one tick with either an encoder sample or a button sample.
   typedef struct packed {
      logic command;
      logic pin_a;
      logic pin_b;
      logic button_pressed;
   } req_type;

   // Result word: event, position and button state after the tick.
   typedef struct packed {
      logic [2:0]        event_code;
      logic signed [7:0] position;
      logic [2:0]        button_state;
   } rsp_type;

   typedef enum logic {
      CMD_ENCODER = 1'b0,
      CMD_BUTTON  = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_CLICK_MIN_TICKS       = 1'b0,
      CSR_LONG_HOLD_EXTRA_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ROT_IDLE    = 3'd0,
      ROT_FWD1    = 3'd1,
      ROT_FWD2    = 3'd2,
      ROT_REV1    = 3'd3,
      ROT_REV2    = 3'd4,
      ROT_END_REV = 3'd5,
      ROT_END_FWD = 3'd6
   } rot_state_type;

   typedef enum logic [2:0] {
      BTN_IDLE       = 3'd0,
      BTN_PRESS      = 3'd1,
      BTN_SHORT      = 3'd2,
      BTN_CLICK_WAIT = 3'd3,
      BTN_LONG       = 3'd4,
      BTN_DOUBLE     = 3'd5,
      BTN_RELEASE    = 3'd6
   } btn_state_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_FWD    = 3'd1,
      EV_REV    = 3'd2,
      EV_SHORT  = 3'd3,
      EV_LONG   = 3'd4,
      EV_CLICK  = 3'd5,
      EV_DOUBLE = 3'd6
   } event_type;

   localparam logic [7:0] SHORT_HOLD_TICKS    = 8'd100;
   localparam logic [7:0] DOUBLE_GAP_TICKS    = 8'd10;
   localparam logic [7:0] CLICK_TIMEOUT_TICKS = 8'd30;

   localparam logic [7:0] CLICK_MIN_RESET       = 8'd5;
   localparam logic [7:0] LONG_HOLD_EXTRA_RESET = 8'd100;

endpackage

`default_nettype wire

[rtl/rotary_encoder_button_decoder_unit.sv]
// Rotary encoder and push-button gesture decoder, top level.
// Depends on rebd_pkg and rotary_encoder_button_decoder_unit_defines.svh.
//
// Usage:
// Each word on the req_ channel is one tick. Its command field selects
// whether the tick samples the encoder channels (pin_a, pin_b) or the push
// button (button_pressed). Every accepted word yields exactly one word on the
// rsp_ channel holding the event code, the wrapping signed detent position and
// the button state as they stand after that tick.
// The block has two stages: an input register that captures the accepted word
// and a result register loaded by the decode logic. A word accepted at one
// clock edge is presented on rsp_ right after the next edge when the result
// register is free. One word per cycle is sustained while the receiver does
// not stall; the decoder state is registered at the same edge as the result.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; req_ready falls only once both are
// full, and rises again in the cycle rsp_ready is seen.
// The csr_ port writes click_min_ticks (index 0) and long_hold_extra_ticks
// (index 1) in the cycle csr_we is high; write it only while the block is idle.
// Synchronous reset empties both stages, puts both state machines in idle,
// clears the tick counter and position, and restores the register defaults
// (5 and 100).
`default_nettype none

`include "rotary_encoder_button_decoder_unit_defines.svh"

module rotary_encoder_button_decoder_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rebd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rebd_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_wdata
);
   import rebd_pkg::*;

   // Configuration registers.
   logic [7:0] click_min_ff;
   logic [7:0] long_extra_ff;

   // Input stage.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Decoder state.
   rot_state_type     rot_ff, rot_in;
   btn_state_type     btn_ff, btn_in;
   logic [7:0]        ticks_ff, ticks_in;
   logic signed [7:0] detent_ff, detent_in;

   // Result stage.
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   event_type ev;

   logic advance;
   logic req_fire;
   logic rest;

   // The input word moves on whenever the result register is empty or
   // being drained this cycle.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign rest = in_data_ff.pin_a && in_data_ff.pin_b;

   // Next state of both machines. The checks run in order so that a later
   // check sees the counter value left by an earlier one, just as the
   // button machine is specified.
   always_comb begin
      rot_in    = rot_ff;
      btn_in    = btn_ff;
      ticks_in  = ticks_ff;
      detent_in = detent_ff;
      ev        = EV_NONE;
      if (advance) begin
         if (cmd_type'(in_data_ff.command) == CMD_ENCODER) begin
            case (rot_ff)
               ROT_IDLE: begin
                  if (!in_data_ff.pin_a && in_data_ff.pin_b) rot_in = ROT_FWD1;
                  if (in_data_ff.pin_a && !in_data_ff.pin_b) rot_in = ROT_REV1;
               end
               ROT_FWD1: begin
                  if (!in_data_ff.pin_a && !in_data_ff.pin_b) rot_in = ROT_FWD2;
                  if (rest) rot_in = ROT_IDLE;
               end
               ROT_FWD2: begin
                  if (in_data_ff.pin_a && !in_data_ff.pin_b) rot_in = ROT_END_FWD;
                  if (rest) rot_in = ROT_IDLE;
               end
               ROT_REV1: begin
                  if (!in_data_ff.pin_a && !in_data_ff.pin_b) rot_in = ROT_REV2;
                  if (rest) rot_in = ROT_IDLE;
               end
               ROT_REV2: begin
                  if (!in_data_ff.pin_a && in_data_ff.pin_b) rot_in = ROT_END_REV;
                  if (rest) rot_in = ROT_IDLE;
               end
               ROT_END_REV: begin
                  // A reverse step always forces the button to release,
                  // but reports only outside press and release.
                  if (rest) begin
                     detent_in = detent_ff - 8'sd1;
                     rot_in    = ROT_IDLE;
                     if (btn_ff != BTN_PRESS && btn_ff != BTN_RELEASE) ev = EV_REV;
                     btn_in = BTN_RELEASE;
                  end
               end
               ROT_END_FWD: begin
                  // A forward step touches the button only when it reports.
                  if (rest) begin
                     detent_in = detent_ff + 8'sd1;
                     rot_in    = ROT_IDLE;
                     if (btn_ff != BTN_PRESS && btn_ff != BTN_RELEASE) begin
                        ev     = EV_FWD;
                        btn_in = BTN_RELEASE;
                     end
                  end
               end
               default: begin
                  rot_in = rot_ff;
               end
            endcase
         end else begin
            case (btn_ff)
               BTN_IDLE: begin
                  if (in_data_ff.button_pressed) begin
                     ticks_in = '0;
                     btn_in   = BTN_PRESS;
                  end
               end
               BTN_PRESS: begin
                  ticks_in = ticks_ff + 8'd1;
                  if (ticks_in > SHORT_HOLD_TICKS) begin
                     ev       = EV_SHORT;
                     btn_in   = BTN_SHORT;
                     ticks_in = '0;
                  end
                  if (!in_data_ff.button_pressed) begin
                     if (ticks_in > click_min_ff) begin
                        btn_in   = BTN_CLICK_WAIT;
                        ticks_in = '0;
                     end else begin
                        btn_in = BTN_RELEASE;
                     end
                  end
               end
               BTN_SHORT: begin
                  ticks_in = ticks_ff + 8'd1;
                  if (ticks_in > long_extra_ff) btn_in = BTN_LONG;
                  if (!in_data_ff.button_pressed) btn_in = BTN_RELEASE;
               end
               BTN_CLICK_WAIT: begin
                  ticks_in = ticks_ff + 8'd1;
                  if (in_data_ff.button_pressed && ticks_in > DOUBLE_GAP_TICKS) begin
                     btn_in   = BTN_DOUBLE;
                     ticks_in = '0;
                  end
                  if (ticks_in >= CLICK_TIMEOUT_TICKS) begin
                     ev     = EV_CLICK;
                     btn_in = BTN_RELEASE;
                  end
               end
               BTN_LONG: begin
                  ev     = EV_LONG;
                  btn_in = BTN_RELEASE;
               end
               BTN_DOUBLE: begin
                  ev     = EV_DOUBLE;
                  btn_in = BTN_RELEASE;
               end
               BTN_RELEASE: begin
                  if (!in_data_ff.button_pressed) btn_in = BTN_IDLE;
               end
               default: begin
                  btn_in = btn_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      if (advance) begin
         rsp_data_in.event_code   = ev;
         rsp_data_in.position     = detent_in;
         rsp_data_in.button_state = btn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         click_min_ff  <= CLICK_MIN_RESET;
         long_extra_ff <= LONG_HOLD_EXTRA_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rot_ff        <= ROT_IDLE;
         btn_ff        <= BTN_IDLE;
         ticks_ff      <= '0;
         detent_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CLICK_MIN_TICKS:       click_min_ff  <= csr_wdata;
               CSR_LONG_HOLD_EXTRA_TICKS: long_extra_ff <= csr_wdata;
               default:                   click_min_ff  <= click_min_ff;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rot_ff       <= rot_in;
         btn_ff       <= btn_in;
         ticks_ff     <= ticks_in;
         detent_ff    <= detent_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Reset leaves both stages empty.
   `REBD_ASSERT_ALWAYS(a_reset_empty,
      reset |=> (!in_valid_ff && !rsp_valid_ff),
      "stage valid after reset")
   // A waiting result always matches the live position and button state.
   `REBD_ASSERT(a_rsp_matches_state,
      rsp_valid_ff |-> (rsp_data_ff.position == detent_ff &&
                        rsp_data_ff.button_state == btn_ff),
      "result out of step with state")
   // State moves only when a word goes through the decoder.
   `REBD_ASSERT(a_state_frozen,
      !advance |=> ($stable(detent_ff) && $stable(ticks_ff) &&
                    $stable(rot_ff) && $stable(btn_ff)),
      "state changed without a word")

endmodule

`default_nettype wire

[dv/rotary_encoder_button_decoder_unit_tb.sv]
// Self-checking testbench for the rotary encoder and button gesture decoder.
// Depends on rebd_pkg and rotary_encoder_button_decoder_unit; reads no files.
// Predicts every result word in-line and checks it in arrival order.
module rotary_encoder_button_decoder_unit_tb;
   import rebd_pkg::*;

   // The watchdog limit is far above the slowest legal run. That run is about
   // 1500 words, each waiting out a random sender gap and receiver stalls.
   localparam int unsigned CYCLE_LIMIT = 300000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   // Decoder state as the testbench believes it stands after each accepted word.
   rot_state_type     rot_state      = ROT_IDLE;
   btn_state_type     btn_state      = BTN_IDLE;
   logic [7:0]        tick_count     = 8'd0;
   logic signed [7:0] position_model = 8'sd0;
   logic [7:0]        click_min      = CLICK_MIN_RESET;
   logic [7:0]        long_extra     = LONG_HOLD_EXTRA_RESET;

   // Results still owed by the block, oldest first.
   rsp_type expected_words[$];

   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   rotary_encoder_button_decoder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog. A lost or stuck word ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles with %0d results owed.",
                  cycle_count, expected_words.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // The receiver stalls at the rate of the current phase. Its ready is
   // redrawn at every rising edge, so stalls land on every phase of the
   // block's two-stage pipe.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Computes the result word of one tick and advances the predicted state.
   // The encoder side follows a full quadrature cycle from rest. Only the
   // return to rest after the last quarter moves the position. The button
   // side counts ticks in an 8-bit counter that wraps.
   function automatic rsp_type decode_tick(input req_type w);
      event_type ev_code;
      rsp_type   result;
      logic      at_rest;
      logic      down;
      ev_code = EV_NONE;
      at_rest = w.pin_a & w.pin_b;
      down    = w.button_pressed;
      if (w.command == CMD_ENCODER) begin
         case (rot_state)
            ROT_IDLE: begin
               if (!w.pin_a && w.pin_b) rot_state = ROT_FWD1;
               if (w.pin_a && !w.pin_b) rot_state = ROT_REV1;
            end
            ROT_FWD1: begin
               if (!w.pin_a && !w.pin_b) rot_state = ROT_FWD2;
               if (at_rest) rot_state = ROT_IDLE;
            end
            ROT_FWD2: begin
               if (w.pin_a && !w.pin_b) rot_state = ROT_END_FWD;
               if (at_rest) rot_state = ROT_IDLE;
            end
            ROT_REV1: begin
               if (!w.pin_a && !w.pin_b) rot_state = ROT_REV2;
               if (at_rest) rot_state = ROT_IDLE;
            end
            ROT_REV2: begin
               if (!w.pin_a && w.pin_b) rot_state = ROT_END_REV;
               if (at_rest) rot_state = ROT_IDLE;
            end
            // A reverse step always forces the button into release. A forward
            // step does so only when it also reports its event. That asymmetry
            // is intended.
            ROT_END_REV: begin
               if (at_rest) begin
                  position_model = position_model - 8'sd1;
                  rot_state = ROT_IDLE;
                  if (btn_state != BTN_PRESS && btn_state != BTN_RELEASE) ev_code = EV_REV;
                  btn_state = BTN_RELEASE;
               end
            end
            ROT_END_FWD: begin
               if (at_rest) begin
                  position_model = position_model + 8'sd1;
                  rot_state = ROT_IDLE;
                  if (btn_state != BTN_PRESS && btn_state != BTN_RELEASE) begin
                     ev_code = EV_FWD;
                     btn_state = BTN_RELEASE;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         case (btn_state)
            BTN_IDLE: begin
               if (down) begin
                  tick_count = 8'd0;
                  btn_state = BTN_PRESS;
               end
            end
            // The short hold report and the release check are both made on the
            // same tick. A release on the reporting tick therefore still ends
            // in release.
            BTN_PRESS: begin
               tick_count = tick_count + 8'd1;
               if (tick_count > SHORT_HOLD_TICKS) begin
                  ev_code = EV_SHORT;
                  btn_state = BTN_SHORT;
                  tick_count = 8'd0;
               end
               if (!down) begin
                  if (tick_count > click_min) begin
                     btn_state = BTN_CLICK_WAIT;
                     tick_count = 8'd0;
                  end else begin
                     btn_state = BTN_RELEASE;
                  end
               end
            end
            BTN_SHORT: begin
               tick_count = tick_count + 8'd1;
               if (tick_count > long_extra) btn_state = BTN_LONG;
               if (!down) btn_state = BTN_RELEASE;
            end
            BTN_CLICK_WAIT: begin
               tick_count = tick_count + 8'd1;
               if (down && tick_count > DOUBLE_GAP_TICKS) begin
                  btn_state = BTN_DOUBLE;
                  tick_count = 8'd0;
               end
               if (tick_count >= CLICK_TIMEOUT_TICKS) begin
                  ev_code = EV_CLICK;
                  btn_state = BTN_RELEASE;
               end
            end
            BTN_LONG: begin
               ev_code = EV_LONG;
               btn_state = BTN_RELEASE;
            end
            BTN_DOUBLE: begin
               ev_code = EV_DOUBLE;
               btn_state = BTN_RELEASE;
            end
            BTN_RELEASE: begin
               if (!down) btn_state = BTN_IDLE;
            end
            default: ;
         endcase
      end
      result.event_code   = ev_code;
      result.position     = position_model;
      result.button_state = btn_state;
      return result;
   endfunction

   // Result checker. Outputs are sampled at the falling edge, where
   // everything driven at the last rising edge has settled. A word seen
   // there with valid and ready both high is taken at the next rising edge.
   always @(negedge clock) begin
      rsp_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("Result word arrived with nothing owed: %p", rsp_data);
            fail_count++;
         end else begin
            owed = expected_words.pop_front();
            words_checked++;
            if (rsp_data.event_code !== owed.event_code) begin
               $error("event_code: expected %0d, got %0d", owed.event_code, rsp_data.event_code);
               fail_count++;
            end
            if (rsp_data.position !== owed.position) begin
               $error("position: expected %0d, got %0d", owed.position, rsp_data.position);
               fail_count++;
            end
            if (rsp_data.button_state !== owed.button_state) begin
               $error("button_state: expected %0d, got %0d",
                      owed.button_state, rsp_data.button_state);
               fail_count++;
            end
         end
      end
   end

   // Sends one word and records its prediction once it is accepted. The task
   // is entered and left at a rising edge. Valid stays high from one word to
   // the next unless the sender draws a gap.
   task automatic send_tick(input req_type w);
      logic taken;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      expected_words.push_back(decode_tick(w));
      words_sent++;
   endtask

   // The field that the command does not select carries random data, so
   // that every bit of the word toggles.
   task automatic enc_tick(input logic a, input logic b);
      req_type w;
      w.command        = CMD_ENCODER;
      w.pin_a          = a;
      w.pin_b          = b;
      w.button_pressed = 1'($urandom_range(0, 1));
      send_tick(w);
   endtask

   task automatic btn_tick(input logic down);
      req_type w;
      w.command        = CMD_BUTTON;
      w.pin_a          = 1'($urandom_range(0, 1));
      w.pin_b          = 1'($urandom_range(0, 1));
      w.button_pressed = down;
      send_tick(w);
   endtask

   // One full detent. With dwell set, each sample may be repeated as a slow hand
   // would produce it. With broken set, one quarter is replaced by random pins.
   task automatic rotate_detent(input bit fwd, input bit broken, input bit dwell);
      logic [1:0]  pins;
      logic [1:0]  pattern [4];
      int unsigned bad_slot;
      if (fwd) begin
         pattern = '{2'b01, 2'b00, 2'b10, 2'b11};
      end else begin
         pattern = '{2'b10, 2'b00, 2'b01, 2'b11};
      end
      bad_slot = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         pins = pattern[i];
         if (broken && i == bad_slot) pins = 2'($urandom_range(0, 3));
         repeat (dwell ? $urandom_range(1, 3) : 1) enc_tick(pins[1], pins[0]);
      end
   endtask

   // Holds the button for some ticks, then leaves it up for some ticks.
   task automatic press_release(input int unsigned hold_len, input int unsigned gap_len);
      repeat (hold_len) btn_tick(1'b1);
      repeat (gap_len) btn_tick(1'b0);
   endtask

   // Returns once every owed result is in and the pipe has had time to empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CLICK_MIN_TICKS:       click_min  = value;
         CSR_LONG_HOLD_EXTRA_TICKS: long_extra = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] click, input logic [7:0] extra);
      wait_idle();
      write_csr(CSR_CLICK_MIN_TICKS, click);
      write_csr(CSR_LONG_HOLD_EXTRA_TICKS, extra);
   endtask

   // Pacing modes: 0 none, 1 sender mostly idle, 2 receiver mostly
   // stalled, 3 both idle now and then.
   task automatic set_pacing(input int unsigned mode);
      case (mode)
         1:       begin send_idle_pct = 81; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 81; end
         3:       begin send_idle_pct = 20; stall_pct = 20; end
         default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // Directed ticks with the reset register values. They cover a clean
   // forward and reverse step and an aborted cycle. They also cover a
   // forward step taken while the button is pressed, which moves only the
   // position, and a reverse step taken while it is pressed, which forces
   // release.
   task automatic test_directed_cases();
      set_pacing(0);
      enc_tick(1'b1, 1'b1);
      rotate_detent(1'b1, 1'b0, 1'b0);
      btn_tick(1'b0);
      rotate_detent(1'b0, 1'b0, 1'b0);
      btn_tick(1'b0);
      enc_tick(1'b0, 1'b1);
      enc_tick(1'b1, 1'b1);
      btn_tick(1'b1);
      rotate_detent(1'b1, 1'b0, 1'b0);
      rotate_detent(1'b0, 1'b0, 1'b0);
      btn_tick(1'b0);
   endtask

   // Turns forward until the position has wrapped past +127, then back
   // until it has wrapped past -128. Random detents follow, some of them
   // slow and some broken.
   task automatic test_rotation();
      set_pacing(0);
      while (position_model != -8'sd120) rotate_detent(1'b1, 1'b0, 1'b0);
      while (position_model != 8'sd120) rotate_detent(1'b0, 1'b0, 1'b0);
      set_pacing(3);
      repeat (20) begin
         if ($urandom_range(0, 7) == 0) enc_tick(1'b1, 1'b1);
         rotate_detent(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0),
                       1'($urandom_range(0, 1)));
      end
   endtask

   // One random button gesture: a click or double click, a short or long
   // hold, a rotation during a press or a click wait, or stray samples.
   task automatic button_gesture();
      int unsigned choice;
      int unsigned extra;
      choice = $urandom_range(0, 9);
      if (choice <= 4) begin
         press_release($urandom_range(1, 14), $urandom_range(1, 40));
         if ($urandom_range(0, 1)) press_release($urandom_range(1, 5), $urandom_range(1, 35));
      end else if (choice <= 6) begin
         // The counter wraps, so with the largest threshold a hold of
         // about 260 ticks still never reaches long hold.
         if (long_extra >= 8'd200) begin
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 12);
         end else begin
            extra = $urandom_range(0, 1) ? 32'(long_extra) + $urandom_range(0, 3) :
                                           $urandom_range(0, 12);
         end
         press_release(100 + $urandom_range(0, 3) + extra, $urandom_range(1, 4));
      end else if (choice == 7) begin
         repeat ($urandom_range(1, 4)) btn_tick(1'b1);
         rotate_detent(1'($urandom_range(0, 1)), 1'b0, 1'b0);
         repeat ($urandom_range(1, 3)) btn_tick(1'b0);
      end else if (choice == 8) begin
         press_release($urandom_range(4, 12), $urandom_range(0, 3));
         rotate_detent(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(1, 4)) btn_tick(1'($urandom_range(0, 1)));
      end
   endtask

   // Gestures under several register settings, the extremes among them, and
   // under every pacing mode.
   task automatic test_button_gestures();
      logic [7:0]  click_set [5];
      logic [7:0]  extra_set [5];
      int unsigned phase_end;
      click_set = '{8'd0, 8'd255, 8'd3, 8'd0, CLICK_MIN_RESET};
      extra_set = '{8'd0, 8'd255, 8'd20, 8'd0, LONG_HOLD_EXTRA_RESET};
      click_set[3] = 8'($urandom_range(0, 255));
      extra_set[3] = 8'($urandom_range(0, 255));
      for (int s = 0; s < 5; s++) begin
         apply_settings(click_set[s], extra_set[s]);
         set_pacing((s + 1) % 4);
         phase_end = words_sent + 50;
         while (words_sent < phase_end) button_gesture();
      end
   endtask

   // Unstructured words, with a gesture or a detent now and then so that the
   // noise lands on deeper states too.
   task automatic test_mixed_noise();
      req_type w;
      int unsigned phase_end;
      apply_settings(8'($urandom_range(0, 15)), 8'($urandom_range(0, 40)));
      set_pacing(2);
      phase_end = words_sent + 150;
      while (words_sent < phase_end) begin
         case ($urandom_range(0, 5))
            0:       button_gesture();
            1:       rotate_detent(1'($urandom_range(0, 1)), 1'b1, 1'b1);
            default: begin
               w = req_type'(4'($urandom_range(0, 15)));
               send_tick(w);
            end
         endcase
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_CLICK_MIN_TICKS;
      csr_wdata <= 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_rotation();
      test_button_gestures();
      test_mixed_noise();

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Sent %0d words and checked %0d results: detents with position wrap,", words_sent,
               words_checked);
      $display("clicks, double clicks, short and long holds, noise, four pacing modes.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/rebd_pkg.sv
rtl/rotary_encoder_button_decoder_unit.sv
dv/rotary_encoder_button_decoder_unit_tb.sv
